/* sv/component_color_transform_macros.svh */
`ifndef COMPONENT_COLOR_TRANSFORM_MACROS_SVH
`define COMPONENT_COLOR_TRANSFORM_MACROS_SVH

// Both macros expect signals named clk and rst in the scope where they are used.

// The consequent must hold in the same cycle as the antecedent.
`define CCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("colour transform: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define CCT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("colour transform: next-cycle check failed");

`endif

/* sv/cct_pkg.sv */
package cct_pkg;

  localparam int SAMPLE_BITS_DEF     = 19;
  localparam int COEF_FRAC_BITS_DEF  = 16;
  localparam int PIPE_STAGES         = 6;
  localparam int CFG_IDX_BITS        = 1;
  localparam int CFG_DATA_BITS       = 1;
  localparam int COEF_MAX_BITS       = 26;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DIRECTION_INVERSE = 1'b0,
    CFG_IRREVERSIBLE_MODE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic inverse;
    logic irrev;
  } cct_mode_t;

  // Standard ICT coefficients in Q24.
  localparam logic [24:0] Q24_AR  = 25'd5016388;
  localparam logic [24:0] Q24_AG  = 25'd9848226;
  localparam logic [24:0] Q24_AB  = 25'd1912603;
  localparam logic [24:0] Q24_ICB = 25'd9467955;
  localparam logic [24:0] Q24_ICR = 25'd11966631;
  localparam logic [24:0] Q24_RCR = 25'd23521657;
  localparam logic [24:0] Q24_BCB = 25'd29729227;
  localparam logic [24:0] Q24_GCR = 25'd11981214;
  localparam logic [24:0] Q24_GCB = 25'd5773644;

  // Rounds a Q24 coefficient half up to the given number of fraction bits.
  function automatic logic [COEF_MAX_BITS-1:0] coef_q(input logic [24:0] q24, input int frac);
    logic [26:0] t;
    t = ({2'b00, q24} << 1) >> (24 - frac);
    t = t + 27'd1;
    return t[26:1];
  endfunction

endpackage

/* sv/cct_stream_if.sv */
interface cct_pixel_if #(
  parameter int SAMPLE_BITS = cct_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] comp_a;
  logic signed [SAMPLE_BITS-1:0] comp_b;
  logic signed [SAMPLE_BITS-1:0] comp_c;
  logic                          last_in;

  modport source (output valid, comp_a, comp_b, comp_c, last_in, input ready);
  modport sink   (input valid, comp_a, comp_b, comp_c, last_in, output ready);
endinterface

interface cct_result_if #(
  parameter int SAMPLE_BITS = cct_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] res_a;
  logic signed [SAMPLE_BITS-1:0] res_b;
  logic signed [SAMPLE_BITS-1:0] res_c;
  logic                          clipped;
  logic                          last_out;

  modport source (output valid, res_a, res_b, res_c, clipped, last_out, input ready);
  modport sink   (input valid, res_a, res_b, res_c, clipped, last_out, output ready);
endinterface

/* sv/cct_datapath.sv */
module cct_datapath #(
  parameter int SAMPLE_BITS    = cct_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = cct_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic [cct_pkg::PIPE_STAGES-1:0]     en,
  input  cct_pkg::cct_mode_t                  mode,
  input  logic signed [SAMPLE_BITS-1:0]       comp_a,
  input  logic signed [SAMPLE_BITS-1:0]       comp_b,
  input  logic signed [SAMPLE_BITS-1:0]       comp_c,
  input  logic                                last_in,
  output logic signed [SAMPLE_BITS-1:0]       res_a,
  output logic signed [SAMPLE_BITS-1:0]       res_b,
  output logic signed [SAMPLE_BITS-1:0]       res_c,
  output logic                                clipped,
  output logic                                last_out
);
  import cct_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int F   = COEF_FRAC_BITS;
  localparam int CW  = F + 1;
  localparam int PW  = S + CW + 1;
  localparam int VW  = S + F + 3;
  localparam int RW  = S + 3;
  localparam int HW  = VW - F;
  localparam int HPW = HW + CW + 1;
  localparam int LPW = F + CW;

  localparam logic [CW-1:0] K_AR  = CW'(coef_q(Q24_AR, F));
  localparam logic [CW-1:0] K_AG  = CW'(coef_q(Q24_AG, F));
  localparam logic [CW-1:0] K_AB  = CW'(coef_q(Q24_AB, F));
  localparam logic [CW-1:0] K_ICB = CW'(coef_q(Q24_ICB, F));
  localparam logic [CW-1:0] K_ICR = CW'(coef_q(Q24_ICR, F));
  localparam logic [CW-1:0] K_RCR = CW'(coef_q(Q24_RCR, F));
  localparam logic [CW-1:0] K_BCB = CW'(coef_q(Q24_BCB, F));
  localparam logic [CW-1:0] K_GCR = CW'(coef_q(Q24_GCR, F));
  localparam logic [CW-1:0] K_GCB = CW'(coef_q(Q24_GCB, F));

  localparam logic signed [VW-1:0]  HALF_V = VW'(64'sd1 <<< (F - 1));
  localparam logic signed [HPW-1:0] HALF_H = HPW'(64'sd1 <<< (F - 1));
  localparam logic signed [RW-1:0]  SAT_HI = RW'((64'sd1 <<< (S - 1)) - 64'sd1);
  localparam logic signed [RW-1:0]  SAT_LO = -SAT_HI - RW'(1);

  // Stage 1: products and the reversible transform.
  logic signed [PW-1:0] op0, op1, op2, m_next [4];
  logic        [CW-1:0] k0, k1, k2;
  logic signed [RW-1:0] ae, be, ce, g, rct [3];
  logic signed [PW-1:0] s1_m [4];
  logic signed [S-1:0]  s1_a, s1_c;
  logic signed [RW-1:0] s1_r [3];
  logic                 s1_last;

  always_comb begin
    op0 = mode.inverse ? PW'(comp_c) : PW'(comp_a);
    op1 = mode.inverse ? PW'(comp_c) : PW'(comp_b);
    op2 = mode.inverse ? PW'(comp_b) : PW'(comp_c);
    k0  = mode.inverse ? K_RCR : K_AR;
    k1  = mode.inverse ? K_GCR : K_AG;
    k2  = mode.inverse ? K_GCB : K_AB;
    m_next[0] = op0 * PW'($signed({1'b0, k0}));
    m_next[1] = op1 * PW'($signed({1'b0, k1}));
    m_next[2] = op2 * PW'($signed({1'b0, k2}));
    m_next[3] = PW'(comp_b) * PW'($signed({1'b0, K_BCB}));

    ae = RW'(comp_a);
    be = RW'(comp_b);
    ce = RW'(comp_c);
    g  = ae - ((be + ce) >>> 2);
    if (mode.inverse) begin
      rct[0] = ce + g;
      rct[1] = g;
      rct[2] = be + g;
    end else begin
      rct[0] = (ae + (be <<< 1) + ce) >>> 2;
      rct[1] = ce - be;
      rct[2] = ae - be;
    end
  end

  // Stage 2: forward luma in fixed point, or the inverse sums with the rounding offset.
  logic signed [VW-1:0] a_sh, v_next [3];
  logic signed [VW-1:0] s2_v [3];
  logic signed [S-1:0]  s2_a, s2_c;
  logic signed [RW-1:0] s2_r [3];
  logic                 s2_last;

  always_comb begin
    a_sh = VW'(s1_a) <<< F;
    if (mode.inverse) begin
      v_next[0] = a_sh + VW'(s1_m[0]) + HALF_V;
      v_next[1] = a_sh - VW'(s1_m[1]) - VW'(s1_m[2]) + HALF_V;
      v_next[2] = a_sh + VW'(s1_m[3]) + HALF_V;
    end else begin
      v_next[0] = VW'(s1_m[0]) + VW'(s1_m[1]) + VW'(s1_m[2]);
      v_next[1] = '0;
      v_next[2] = '0;
    end
  end

  // Stage 3: chroma differences against the luma, rounding of the other ICT results.
  logic signed [RW-1:0] r3_next [3];
  logic signed [VW-1:0] d_next [2];
  logic signed [RW-1:0] s3_r [3];
  logic signed [VW-1:0] s3_d [2];
  logic                 s3_last;

  always_comb begin
    d_next[0] = (VW'(s2_c) <<< F) - s2_v[0];
    d_next[1] = (VW'(s2_a) <<< F) - s2_v[0];
    if (!mode.irrev) begin
      r3_next = s2_r;
    end else if (mode.inverse) begin
      for (int i = 0; i < 3; i++) r3_next[i] = RW'(s2_v[i] >>> F);
    end else begin
      r3_next[0] = RW'((s2_v[0] + HALF_V) >>> F);
      r3_next[1] = '0;
      r3_next[2] = '0;
    end
  end

  // Stage 4: chroma scaling, split into whole and fraction parts of the difference.
  logic signed [HW-1:0]  hi [2];
  logic        [F-1:0]   lo [2];
  logic        [CW-1:0]  kc [2];
  logic signed [HPW-1:0] ph_next [2];
  logic        [LPW-1:0] pl_next [2];
  logic signed [RW-1:0]  s4_r [3];
  logic signed [HPW-1:0] s4_ph [2];
  logic        [LPW-1:0] s4_pl [2];
  logic                  s4_last;

  always_comb begin
    kc[0] = K_ICB;
    kc[1] = K_ICR;
    for (int i = 0; i < 2; i++) begin
      hi[i] = $signed(s3_d[i][VW-1:F]);
      lo[i] = s3_d[i][F-1:0];
      ph_next[i] = HPW'(hi[i]) * HPW'($signed({1'b0, kc[i]}));
      pl_next[i] = LPW'(lo[i]) * LPW'(kc[i]);
    end
  end

  // Stage 5: recombine and round the chroma.
  logic signed [HPW-1:0] q [2];
  logic signed [RW-1:0]  r5_next [3];
  logic signed [RW-1:0]  s5_r [3];
  logic                  s5_last;

  always_comb begin
    r5_next = s4_r;
    for (int i = 0; i < 2; i++) begin
      q[i] = s4_ph[i] + $signed(HPW'(s4_pl[i] >> F)) + HALF_H;
    end
    if (mode.irrev && !mode.inverse) begin
      r5_next[1] = RW'(q[0] >>> F);
      r5_next[2] = RW'(q[1] >>> F);
    end
  end

  // Stage 6: saturation into the output register.
  logic signed [S-1:0] sat_v [3];
  logic                clip_next;

  always_comb begin
    clip_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (s5_r[i] > SAT_HI) begin
        sat_v[i]  = SAT_HI[S-1:0];
        clip_next = 1'b1;
      end else if (s5_r[i] < SAT_LO) begin
        sat_v[i]  = SAT_LO[S-1:0];
        clip_next = 1'b1;
      end else begin
        sat_v[i] = s5_r[i][S-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_m    <= m_next;
      s1_a    <= comp_a;
      s1_c    <= comp_c;
      s1_r    <= rct;
      s1_last <= last_in;
    end
    if (en[1]) begin
      s2_v    <= v_next;
      s2_a    <= s1_a;
      s2_c    <= s1_c;
      s2_r    <= s1_r;
      s2_last <= s1_last;
    end
    if (en[2]) begin
      s3_r    <= r3_next;
      s3_d    <= d_next;
      s3_last <= s2_last;
    end
    if (en[3]) begin
      s4_r    <= s3_r;
      s4_ph   <= ph_next;
      s4_pl   <= pl_next;
      s4_last <= s3_last;
    end
    if (en[4]) begin
      s5_r    <= r5_next;
      s5_last <= s4_last;
    end
    if (en[5]) begin
      res_a    <= sat_v[0];
      res_b    <= sat_v[1];
      res_c    <= sat_v[2];
      clipped  <= clip_next;
      last_out <= s5_last;
    end
  end

endmodule

/* sv/component_color_transform.sv */
// Channel  Side  Beat contents
// pixel    in    comp_a, comp_b, comp_c, last_in
// result   out   res_a, res_b, res_c, clipped, last_out
// cfg      in    cfg_index, cfg_data, taken when cfg_we is high
//
// One beat per clock sustained while result.ready stays high.
// The depth is set by the forward ICT: luma sum, chroma difference, then a second
// multiply and its rounding, each in a stage of its own, with saturation last.
// Reset clears both mode registers and every stage valid bit.
// A full stage holds while the one after it is full and stalled; empty stages
// still fill, so pixel.ready follows the free space in the pipeline.

`include "component_color_transform_macros.svh"

module component_color_transform #(
  parameter int SAMPLE_BITS    = cct_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = cct_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  cct_pixel_if.sink                         pixel,
  cct_result_if.source                      result,
  input  logic                              cfg_we,
  input  logic [cct_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [cct_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import cct_pkg::*;

  localparam logic signed [SAMPLE_BITS-1:0] RES_MAX = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] RES_MIN = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  cct_mode_t              mode;
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;
  logic                   res_at_rail;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        CFG_DIRECTION_INVERSE: mode.inverse <= cfg_data[0];
        CFG_IRREVERSIBLE_MODE: mode.irrev   <= cfg_data[0];
      endcase
    end
  end

  // A stage may load when it is empty or when its contents move on this cycle.
  always_comb begin
    en[PIPE_STAGES-1] = !vld[PIPE_STAGES-1] || result.ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pixel.valid;
      for (int k = 1; k < PIPE_STAGES; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  assign pixel.ready  = en[0];
  assign result.valid = vld[PIPE_STAGES-1];

  cct_datapath #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .en       (en),
    .mode     (mode),
    .comp_a   (pixel.comp_a),
    .comp_b   (pixel.comp_b),
    .comp_c   (pixel.comp_c),
    .last_in  (pixel.last_in),
    .res_a    (result.res_a),
    .res_b    (result.res_b),
    .res_c    (result.res_c),
    .clipped  (result.clipped),
    .last_out (result.last_out)
  );

  assign res_at_rail = result.res_a == RES_MAX || result.res_a == RES_MIN ||
                       result.res_b == RES_MAX || result.res_b == RES_MIN ||
                       result.res_c == RES_MAX || result.res_c == RES_MIN;

  `CCT_ASSERT_NEXT(a_accept_fills_first, pixel.valid && pixel.ready, vld[0])
  `CCT_ASSERT_NEXT(a_mid_stage_holds, vld[2] && !en[2], vld[2])
  `CCT_ASSERT_IMP(a_clip_at_bound, result.valid && result.clipped, res_at_rail)

endmodule

/* tb/tb_component_color_transform.sv */
module tb_component_color_transform;
  timeunit 1ns;
  timeprecision 1ps;

  import cct_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int FRAC = COEF_FRAC_BITS_DEF;
  localparam longint SMAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SMIN = -SMAX - 1;
  localparam longint ONE = longint'(1) <<< FRAC;
  localparam int RANDOM_BEATS = 1650;
  localparam int PHASES = 10;
  localparam int CYCLE_LIMIT = 400000;

  typedef logic signed [SB-1:0] sample_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    logic    last;
  } pixel_t;

  typedef struct packed {
    sample_t a;
    sample_t b;
    sample_t c;
    logic    clipped;
    logic    last;
  } triple_t;

  // Rounds a Q24 coefficient half up to the working number of fraction bits.
  function automatic longint to_q(logic [24:0] q24);
    longint t;
    t = (longint'(q24) << 1) >> (24 - FRAC);
    return (t + 1) >> 1;
  endfunction

  localparam longint K_AR  = to_q(Q24_AR);
  localparam longint K_AG  = to_q(Q24_AG);
  localparam longint K_AB  = to_q(Q24_AB);
  localparam longint K_ICB = to_q(Q24_ICB);
  localparam longint K_ICR = to_q(Q24_ICR);
  localparam longint K_RCR = to_q(Q24_RCR);
  localparam longint K_BCB = to_q(Q24_BCB);
  localparam longint K_GCR = to_q(Q24_GCR);
  localparam longint K_GCB = to_q(Q24_GCB);

  function automatic longint round_q(longint x);
    return (x + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic triple_t transform_triple(pixel_t p, cct_mode_t m);
    longint a, b, c, luma, g;
    longint r[3];
    triple_t t;
    int i;
    a = longint'($signed(p.a));
    b = longint'($signed(p.b));
    c = longint'($signed(p.c));
    if (!m.inverse && !m.irrev) begin
      r[0] = (a + 2 * b + c) >>> 2;
      r[1] = c - b;
      r[2] = a - b;
    end else if (!m.inverse) begin
      // Luma stays at full fraction precision until after the chroma products.
      luma = K_AR * a + K_AG * b + K_AB * c;
      r[0] = round_q(luma);
      r[1] = round_q(((c * ONE - luma) * K_ICB) >>> FRAC);
      r[2] = round_q(((a * ONE - luma) * K_ICR) >>> FRAC);
    end else if (!m.irrev) begin
      g = a - ((b + c) >>> 2);
      r[0] = c + g;
      r[1] = g;
      r[2] = b + g;
    end else begin
      luma = a * ONE;
      r[0] = round_q(luma + K_RCR * c);
      r[1] = round_q(luma - K_GCR * c - K_GCB * b);
      r[2] = round_q(luma + K_BCB * b);
    end
    t.clipped = 1'b0;
    for (i = 0; i < 3; i++) begin
      if (r[i] > SMAX) begin
        r[i] = SMAX;
        t.clipped = 1'b1;
      end else if (r[i] < SMIN) begin
        r[i] = SMIN;
        t.clipped = 1'b1;
      end
    end
    t.a = r[0][SB-1:0];
    t.b = r[1][SB-1:0];
    t.c = r[2][SB-1:0];
    t.last = p.last;
    return t;
  endfunction

  // Mix of full-range words, values near zero, the rails and a typical image range.
  function automatic sample_t rand_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5: return sample_t'(int'($urandom_range(0, 1023)) - 512);
      6: return $urandom_range(0, 1) ? sample_t'(SMAX) : sample_t'(SMIN);
      7: return sample_t'(SMAX - longint'($urandom_range(0, 255)));
      8: return sample_t'(SMIN + longint'($urandom_range(0, 255)));
      default: return sample_t'($urandom_range(0, 4095));
    endcase
  endfunction

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  cct_pixel_if #(.SAMPLE_BITS(SB)) pixel_ch ();
  cct_result_if #(.SAMPLE_BITS(SB)) result_ch ();

  component_color_transform #(
    .SAMPLE_BITS(SB),
    .COEF_FRAC_BITS(FRAC)
  ) uut (
    .clk(clk),
    .rst(rst),
    .pixel(pixel_ch),
    .result(result_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  cct_mode_t cfg_mode = '0;
  pixel_t pending_pixels[$];
  triple_t expected_triples[$];

  int failures = 0;
  int beats_sent = 0;
  int results_seen = 0;
  int clip_count = 0;
  int last_count = 0;
  int settings_used = 1;
  int cycles = 0;

  function automatic void note_failure(string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endfunction

  // Pixel driver: bursts of beats separated by random gaps.
  int gap_left;
  int burst_left;
  pixel_t taken_pixel;
  pixel_t next_pixel;

  always @(posedge clk) begin
    if (rst) begin
      pixel_ch.valid <= 1'b0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (pixel_ch.valid && pixel_ch.ready) begin
        taken_pixel = {pixel_ch.comp_a, pixel_ch.comp_b, pixel_ch.comp_c, pixel_ch.last_in};
        expected_triples.push_back(transform_triple(taken_pixel, cfg_mode));
        beats_sent++;
      end
      if (!pixel_ch.valid || pixel_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          pixel_ch.valid <= 1'b0;
        end else if (pending_pixels.size() > 0) begin
          next_pixel = pending_pixels.pop_front();
          pixel_ch.comp_a <= next_pixel.a;
          pixel_ch.comp_b <= next_pixel.b;
          pixel_ch.comp_c <= next_pixel.c;
          pixel_ch.last_in <= next_pixel.last;
          pixel_ch.valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end
        end else begin
          pixel_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor; ready follows a rotating stall pattern that is reloaded now and then.
  logic [15:0] stall_pattern;
  triple_t got_triple;
  triple_t want_triple;

  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_pattern = '1;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        got_triple = {result_ch.res_a, result_ch.res_b, result_ch.res_c,
                      result_ch.clipped, result_ch.last_out};
        if (expected_triples.size() == 0) begin
          note_failure($sformatf("unexpected result beat: a=%0d b=%0d c=%0d clip=%b last=%b",
                                 $signed(got_triple.a), $signed(got_triple.b),
                                 $signed(got_triple.c), got_triple.clipped,
                                 got_triple.last));
        end else begin
          want_triple = expected_triples.pop_front();
          if (got_triple.a !== want_triple.a || got_triple.b !== want_triple.b ||
              got_triple.c !== want_triple.c || got_triple.clipped !== want_triple.clipped ||
              got_triple.last !== want_triple.last) begin
            note_failure($sformatf(
              "result %0d: want %0d %0d %0d clip=%b last=%b, got %0d %0d %0d clip=%b last=%b",
              results_seen, $signed(want_triple.a), $signed(want_triple.b),
              $signed(want_triple.c), want_triple.clipped, want_triple.last,
              $signed(got_triple.a), $signed(got_triple.b), $signed(got_triple.c),
              got_triple.clipped, got_triple.last));
          end
          results_seen++;
          if (want_triple.clipped) clip_count++;
          if (want_triple.last) last_count++;
        end
      end
      if ($urandom_range(0, 47) == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = ~(16'h1 << $urandom_range(0, 15));
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
      end else begin
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
      result_ch.ready <= stall_pattern[0];
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("run stopped at the cycle limit with %0d results still awaited",
             expected_triples.size());
    $display("component_color_transform regression: fail");
    $finish;
  end

  // Sampled on the falling edge, so that a beat launched on a rising edge is always seen.
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || pixel_ch.valid || expected_triples.size() != 0)
      @(negedge clk);
    repeat (PIPE_STAGES + 4) @(posedge clk);
  endtask

  // Mode registers are only touched once the pipeline has emptied.
  task automatic apply_mode(cct_mode_t m);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIRECTION_INVERSE;
    cfg_data <= m.inverse;
    @(posedge clk);
    cfg_index <= CFG_IRREVERSIBLE_MODE;
    cfg_data <= m.irrev;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_mode = m;
    settings_used++;
  endtask

  cct_mode_t phase_modes[PHASES] = '{
    '{1'b1, 1'b1}, '{1'b0, 1'b1}, '{1'b1, 1'b0}, '{1'b0, 1'b0}, '{1'b1, 1'b1},
    '{1'b1, 1'b0}, '{1'b0, 1'b1}, '{1'b0, 1'b0}, '{1'b0, 1'b1}, '{1'b1, 1'b1}
  };

  initial begin
    pixel_t px;
    int m;
    int k;
    pixel_ch.valid = 1'b0;
    pixel_ch.comp_a = '0;
    pixel_ch.comp_b = '0;
    pixel_ch.comp_c = '0;
    pixel_ch.last_in = 1'b0;
    result_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed beats in every mode; the first batch runs on the reset mode.
    for (m = 0; m < 4; m++) begin
      if (m > 0) apply_mode(cct_mode_t'(m[1:0]));
      for (k = 0; k < 6; k++) begin
        case (k)
          0: px = {sample_t'(SMAX), sample_t'(SMAX), sample_t'(SMAX), 1'b1};
          1: px = {sample_t'(SMIN), sample_t'(SMIN), sample_t'(SMIN), 1'b0};
          2: px = {sample_t'(SMAX), sample_t'(SMIN), sample_t'(SMAX), 1'b0};
          3: px = {sample_t'(SMIN), sample_t'(SMAX), sample_t'(SMIN), 1'b1};
          // Small negative sums exercise the floor behaviour of the divide by four.
          4: px = {sample_t'(-1), sample_t'(0), sample_t'(-2), 1'b0};
          default: px = {sample_t'(3), sample_t'(-7), sample_t'(2), 1'b1};
        endcase
        pending_pixels.push_back(px);
      end
    end

    for (m = 0; m < PHASES; m++) begin
      apply_mode(phase_modes[m]);
      for (k = 0; k < RANDOM_BEATS / PHASES; k++) begin
        px.a = rand_sample();
        px.b = rand_sample();
        px.c = rand_sample();
        px.last = ($urandom_range(0, 15) == 0);
        pending_pixels.push_back(px);
      end
    end

    wait_drained();
    repeat (PIPE_STAGES * 4) @(posedge clk);
    if (expected_triples.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_triples.size()));

    $display("%0d pixel beats in, %0d results checked over %0d mode settings, %0d cycles",
             beats_sent, results_seen, settings_used, cycles);
    $display("%0d results saturated, %0d run ends passed through", clip_count, last_count);
    if (failures == 0) begin
      $display("component_color_transform regression: pass");
    end else begin
      $display("component_color_transform regression: fail");
    end
    $finish;
  end

endmodule
